FILE: sv/tqg_pkg.sv
`default_nettype none

package tqg_pkg;

  localparam int MAX_TILESETS = 8;
  localparam int MAX_MAP_DIM  = 1024;

  localparam int TBL_AW   = (MAX_TILESETS > 1) ? $clog2(MAX_TILESETS) : 1;
  localparam int SLOT_W   = 3;
  localparam int GID_W    = 32;
  localparam int ID_W     = 29;
  localparam int POS_W    = 10;
  localparam int COLS_W   = 10;
  localparam int PIX_W    = 8;
  localparam int CNT_W    = 4;
  localparam int XY_W     = 18;
  localparam int TV_W     = 37;
  localparam int CORNER_W = 2;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 8;
  localparam int STEP_W   = $clog2(ID_W);

  localparam int FLAG_H_BIT = 31;
  localparam int FLAG_V_BIT = 30;
  localparam int FLAG_D_BIT = 29;

  localparam logic [0:0] OP_LOAD = 1'b0;
  localparam logic [0:0] OP_TILE = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_MAP_TILE_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MAP_TILE_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_TILESETS_IN_USE = 2'd2;

  localparam logic [CORNER_W-1:0] CORNER_TL = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_TR = 2'd1;
  localparam logic [CORNER_W-1:0] CORNER_BR = 2'd2;
  localparam logic [CORNER_W-1:0] CORNER_BL = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   first_gid;
    logic [COLS_W-1:0] columns;
    logic [PIX_W-1:0]  src_width;
    logic [PIX_W-1:0]  src_height;
  } tqg_entry_t;

endpackage

`default_nettype wire

FILE: sv/tqg_if.sv
`default_nettype none

interface tqg_in_if import tqg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [0:0]        operation;
  logic [GID_W-1:0]  raw_gid;
  logic [POS_W-1:0]  tile_col;
  logic [POS_W-1:0]  tile_row;
  logic [SLOT_W-1:0] entry_slot;
  logic [ID_W-1:0]   entry_first_gid;
  logic [COLS_W-1:0] entry_columns;
  logic [PIX_W-1:0]  entry_src_width;
  logic [PIX_W-1:0]  entry_src_height;

  modport source (output valid, operation, raw_gid, tile_col, tile_row, entry_slot,
                  entry_first_gid, entry_columns, entry_src_width, entry_src_height,
                  input ready);
  modport sink   (input valid, operation, raw_gid, tile_col, tile_row, entry_slot,
                  entry_first_gid, entry_columns, entry_src_width, entry_src_height,
                  output ready);
endinterface

interface tqg_out_if import tqg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CORNER_W-1:0] corner;
  logic [XY_W-1:0]     screen_x;
  logic [XY_W-1:0]     screen_y;
  logic [XY_W-1:0]     tex_u;
  logic [TV_W-1:0]     tex_v;
  logic [SLOT_W-1:0]   tileset_slot;
  logic                last_corner;

  modport source (output valid, corner, screen_x, screen_y, tex_u, tex_v, tileset_slot,
                  last_corner, input ready);
  modport sink   (input valid, corner, screen_x, screen_y, tex_u, tex_v, tileset_slot,
                  last_corner, output ready);
endinterface

`default_nettype wire

FILE: sv/tile_gid_quad_generator_top.sv
// Channel   Dir  Transaction
// in_tile   in   load a tileset entry, or present one map tile
// out_quad  out  one quad corner, four per drawn tile
// cfg_*     in   register write, no handshake
//
// A load is taken in the idle state. A tile is accepted, then the table is
// searched one entry at a time (up to 8, one read per cycle on the table
// port), the ID offset goes through the bit-serial divider, the multiply
// step forms the coordinates and four corners are sent. A stalled corner
// holds until taken. Synchronous active-low reset clears control state and
// the tileset count and sets map tile sizes to 16; the table is not cleared.
`default_nettype none

module tile_gid_quad_generator_top import tqg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  tqg_in_if.sink                 in_tile,
  tqg_out_if.source              out_quad,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_MULT   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [PIX_W-1:0] map_w_r, map_h_r;
  logic [CNT_W-1:0] in_use_r;

  tqg_entry_t tbl_mem [MAX_TILESETS];
  tqg_entry_t rd_q_r;
  logic [TBL_AW-1:0] rd_addr;

  logic [TBL_AW-1:0] k_r, k_nxt;
  tqg_entry_t        hit_r, hit_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [2:0]        flags_r, flags_nxt;
  logic [POS_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [COLS_W-1:0] rem_r, rem_nxt;
  logic [ID_W-1:0]   quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CORNER_W-1:0] corner_r, corner_nxt;

  logic [XY_W-1:0] sx0_r, sx1_r, sy0_r, sy1_r, tu0_r, tu1_r;
  logic [TV_W-1:0] tv0_r, tv1_r;

  logic              in_fire, out_fire, is_tile, pos_ok, tbl_we;
  logic [CNT_W-1:0]  cnt_eff;
  logic [COLS_W:0]   trial;
  logic              ge;
  logic [CORNER_W-1:0] tex_p;

  function automatic logic [CORNER_W-1:0] tex_src(input logic [CORNER_W-1:0] k,
                                                  input logic h, input logic v,
                                                  input logic d);
    logic [CORNER_W-1:0] p;
    p = k;
    if (v) p = p ^ CORNER_BL;
    if (h) p = p ^ CORNER_TR;
    if (d) begin
      if (p == CORNER_TR) p = CORNER_BL;
      else if (p == CORNER_BL) p = CORNER_TR;
    end
    return p;
  endfunction

  assign in_tile.ready = (state_r == ST_IDLE);
  assign in_fire  = in_tile.valid && in_tile.ready;
  assign out_fire = out_quad.valid && out_quad.ready;
  assign is_tile  = (in_tile.operation == OP_TILE);

  assign cnt_eff = (32'(in_use_r) > MAX_TILESETS) ? CNT_W'(MAX_TILESETS) : in_use_r;
  assign pos_ok  = (32'(in_tile.tile_col) < MAX_MAP_DIM) &&
                   (32'(in_tile.tile_row) < MAX_MAP_DIM);
  assign tbl_we  = in_fire && !is_tile && (32'(in_tile.entry_slot) < MAX_TILESETS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r  <= PIX_W'(16);
      map_h_r  <= PIX_W'(16);
      in_use_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_TILE_WIDTH:  map_w_r  <= cfg_wdata[PIX_W-1:0];
        CFG_MAP_TILE_HEIGHT: map_h_r  <= cfg_wdata[PIX_W-1:0];
        CFG_TILESETS_IN_USE: in_use_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[in_tile.entry_slot[TBL_AW-1:0]] <= '{
        first_gid:  in_tile.entry_first_gid,
        columns:    in_tile.entry_columns,
        src_width:  in_tile.entry_src_width,
        src_height: in_tile.entry_src_height
      };
    end
    rd_q_r <= tbl_mem[rd_addr];
  end

  assign trial = {rem_r, quo_r[ID_W-1]};
  assign ge    = (trial >= {1'b0, hit_r.columns});

  always_comb begin
    state_nxt  = state_r;
    rd_addr    = k_r;
    k_nxt      = k_r;
    hit_nxt    = hit_r;
    id_nxt     = id_r;
    flags_nxt  = flags_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    step_nxt   = step_r;
    corner_nxt = corner_r;
    unique case (state_r)
      ST_IDLE: begin
        rd_addr = TBL_AW'(cnt_eff - CNT_W'(1));
        if (in_fire && is_tile) begin
          id_nxt    = in_tile.raw_gid[ID_W-1:0];
          flags_nxt = {in_tile.raw_gid[FLAG_H_BIT], in_tile.raw_gid[FLAG_V_BIT],
                       in_tile.raw_gid[FLAG_D_BIT]};
          col_nxt   = in_tile.tile_col;
          row_nxt   = in_tile.tile_row;
          k_nxt     = TBL_AW'(cnt_eff - CNT_W'(1));
          if ((in_tile.raw_gid != '0) && pos_ok && (cnt_eff != '0)) begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        rd_addr = k_r - TBL_AW'(1);
        if (id_r >= rd_q_r.first_gid) begin
          hit_nxt  = rd_q_r;
          quo_nxt  = id_r - rd_q_r.first_gid;
          rem_nxt  = '0;
          step_nxt = '0;
          state_nxt = (rd_q_r.columns == '0) ? ST_IDLE : ST_DIVIDE;
        end else if (k_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_r - TBL_AW'(1);
        end
      end
      ST_DIVIDE: begin
        rem_nxt  = ge ? COLS_W'(trial - {1'b0, hit_r.columns}) : COLS_W'(trial);
        quo_nxt  = {quo_r[ID_W-2:0], ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ID_W - 1)) state_nxt = ST_MULT;
      end
      ST_MULT: begin
        corner_nxt = CORNER_TL;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire) begin
          corner_nxt = corner_r + CORNER_W'(1);
          if (corner_r == CORNER_BL) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      corner_r <= CORNER_TL;
      k_r      <= '0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
      k_r      <= k_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r   <= hit_nxt;
    id_r    <= id_nxt;
    flags_r <= flags_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    if (state_r == ST_MULT) begin
      sx0_r <= XY_W'(col_r) * XY_W'(map_w_r);
      sx1_r <= (XY_W'(col_r) + XY_W'(1)) * XY_W'(map_w_r);
      sy0_r <= XY_W'(row_r) * XY_W'(map_h_r);
      sy1_r <= (XY_W'(row_r) + XY_W'(1)) * XY_W'(map_h_r);
      tu0_r <= XY_W'(rem_r) * XY_W'(hit_r.src_width);
      tu1_r <= (XY_W'(rem_r) + XY_W'(1)) * XY_W'(hit_r.src_width);
      tv0_r <= TV_W'(quo_r) * TV_W'(hit_r.src_height);
      tv1_r <= (TV_W'(quo_r) + TV_W'(1)) * TV_W'(hit_r.src_height);
    end
  end

  // flags_r: {h, v, d}
  assign tex_p = tex_src(corner_r, flags_r[2], flags_r[1], flags_r[0]);

  assign out_quad.valid        = (state_r == ST_EMIT);
  assign out_quad.corner       = corner_r;
  assign out_quad.screen_x     = (corner_r == CORNER_TR || corner_r == CORNER_BR) ?
                                 sx1_r : sx0_r;
  assign out_quad.screen_y     = (corner_r == CORNER_BR || corner_r == CORNER_BL) ?
                                 sy1_r : sy0_r;
  assign out_quad.tex_u        = (tex_p == CORNER_TR || tex_p == CORNER_BR) ? tu1_r : tu0_r;
  assign out_quad.tex_v        = (tex_p == CORNER_BR || tex_p == CORNER_BL) ? tv1_r : tv0_r;
  assign out_quad.tileset_slot = SLOT_W'(k_r);
  assign out_quad.last_corner  = (corner_r == CORNER_BL);

endmodule

`default_nettype wire

FILE: tb/tb_tile_gid_quad_generator_top.sv
module tb_tile_gid_quad_generator_top import tqg_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [0:0]        operation;
    logic [GID_W-1:0]  raw_gid;
    logic [POS_W-1:0]  tile_col;
    logic [POS_W-1:0]  tile_row;
    logic [SLOT_W-1:0] entry_slot;
    logic [ID_W-1:0]   entry_first_gid;
    logic [COLS_W-1:0] entry_columns;
    logic [PIX_W-1:0]  entry_src_width;
    logic [PIX_W-1:0]  entry_src_height;
  } tile_txn_t;

  typedef struct packed {
    logic [CORNER_W-1:0] corner;
    logic [XY_W-1:0]     screen_x;
    logic [XY_W-1:0]     screen_y;
    logic [XY_W-1:0]     tex_u;
    logic [TV_W-1:0]     tex_v;
    logic [SLOT_W-1:0]   tileset_slot;
    logic                last_corner;
  } quad_corner_t;

  class quad_predictor;
    tqg_entry_t       tileset [MAX_TILESETS];
    logic [PIX_W-1:0] map_w = 8'd16;
    logic [PIX_W-1:0] map_h = 8'd16;
    logic [CNT_W-1:0] in_use = '0;
    quad_corner_t     pending_corners[$];
    int unsigned      fail_count = 0;

    task report(string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void note_transaction(tile_txn_t t);
      int hit;
      int n;
      int tmp;
      int perm [4];
      logic [ID_W-1:0] id;
      longint unsigned col, row, mw, mh, ofs, cols, scol, srow, sw, sh;
      longint unsigned sx [4], sy [4], tu [4], tv [4];
      quad_corner_t c;
      if (t.operation == OP_LOAD) begin
        tileset[t.entry_slot] = '{t.entry_first_gid, t.entry_columns,
                                  t.entry_src_width, t.entry_src_height};
        return;
      end
      if (t.raw_gid == '0) return;
      id = t.raw_gid[ID_W-1:0];
      n = (in_use > MAX_TILESETS) ? MAX_TILESETS : int'(in_use);
      hit = -1;
      for (int k = n - 1; k >= 0; k--) begin
        if (id >= tileset[k].first_gid) begin
          hit = k;
          break;
        end
      end
      if (hit < 0) return;
      if (tileset[hit].columns == '0) return;
      ofs  = 64'(id - tileset[hit].first_gid);
      cols = 64'(tileset[hit].columns);
      sw   = 64'(tileset[hit].src_width);
      sh   = 64'(tileset[hit].src_height);
      scol = ofs % cols;
      srow = ofs / cols;
      col  = 64'(t.tile_col);
      row  = 64'(t.tile_row);
      mw   = 64'(map_w);
      mh   = 64'(map_h);
      sx[0] = col * mw;        sy[0] = row * mh;
      sx[1] = (col + 1) * mw;  sy[1] = sy[0];
      sx[2] = sx[1];           sy[2] = (row + 1) * mh;
      sx[3] = sx[0];           sy[3] = sy[2];
      tu[0] = scol * sw;       tv[0] = srow * sh;
      tu[1] = (scol + 1) * sw; tv[1] = tv[0];
      tu[2] = tu[1];           tv[2] = (srow + 1) * sh;
      tu[3] = tu[0];           tv[3] = tv[2];
      // texture corners: diagonal, then horizontal, then vertical
      perm = '{0, 1, 2, 3};
      if (t.raw_gid[FLAG_D_BIT]) begin
        tmp = perm[1]; perm[1] = perm[3]; perm[3] = tmp;
      end
      if (t.raw_gid[FLAG_H_BIT]) begin
        tmp = perm[0]; perm[0] = perm[1]; perm[1] = tmp;
        tmp = perm[2]; perm[2] = perm[3]; perm[3] = tmp;
      end
      if (t.raw_gid[FLAG_V_BIT]) begin
        tmp = perm[0]; perm[0] = perm[3]; perm[3] = tmp;
        tmp = perm[1]; perm[1] = perm[2]; perm[2] = tmp;
      end
      for (int k = 0; k < 4; k++) begin
        c.corner       = k[CORNER_W-1:0];
        c.screen_x     = sx[k][XY_W-1:0];
        c.screen_y     = sy[k][XY_W-1:0];
        c.tex_u        = tu[perm[k]][XY_W-1:0];
        c.tex_v        = tv[perm[k]][TV_W-1:0];
        c.tileset_slot = hit[SLOT_W-1:0];
        c.last_corner  = (k[CORNER_W-1:0] == CORNER_BL);
        pending_corners = {pending_corners, c};
      end
    endfunction

    task check_corner(quad_corner_t got);
      quad_corner_t want;
      if (pending_corners.size() == 0) begin
        report($sformatf("unexpected corner %0d x=%0d y=%0d", got.corner, got.screen_x,
                         got.screen_y));
        return;
      end
      want = pending_corners.pop_front();
      if (got.corner !== want.corner)
        report($sformatf("corner got %0d want %0d", got.corner, want.corner));
      if (got.screen_x !== want.screen_x)
        report($sformatf("corner %0d screen_x got %0d want %0d", want.corner,
                         got.screen_x, want.screen_x));
      if (got.screen_y !== want.screen_y)
        report($sformatf("corner %0d screen_y got %0d want %0d", want.corner,
                         got.screen_y, want.screen_y));
      if (got.tex_u !== want.tex_u)
        report($sformatf("corner %0d tex_u got %0d want %0d", want.corner,
                         got.tex_u, want.tex_u));
      if (got.tex_v !== want.tex_v)
        report($sformatf("corner %0d tex_v got %0d want %0d", want.corner,
                         got.tex_v, want.tex_v));
      if (got.tileset_slot !== want.tileset_slot)
        report($sformatf("corner %0d tileset_slot got %0d want %0d", want.corner,
                         got.tileset_slot, want.tileset_slot));
      if (got.last_corner !== want.last_corner)
        report($sformatf("corner %0d last_corner got %0d want %0d", want.corner,
                         got.last_corner, want.last_corner));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  tqg_in_if  in_tile ();
  tqg_out_if out_quad ();

  tile_gid_quad_generator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tile   (in_tile),
    .out_quad  (out_quad),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  quad_predictor pred = new;
  bit in_high;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[tile_gid_quad_generator_top] ERROR");
    $finish;
  end

  function automatic tile_txn_t tile_txn(logic [GID_W-1:0] raw, logic [POS_W-1:0] col,
                                         logic [POS_W-1:0] row);
    tile_txn_t t;
    t.operation        = OP_TILE;
    t.raw_gid          = raw;
    t.tile_col         = col;
    t.tile_row         = row;
    t.entry_slot       = SLOT_W'($urandom);
    t.entry_first_gid  = ID_W'($urandom);
    t.entry_columns    = COLS_W'($urandom);
    t.entry_src_width  = PIX_W'($urandom);
    t.entry_src_height = PIX_W'($urandom);
    return t;
  endfunction

  function automatic tile_txn_t load_txn(int slot, logic [ID_W-1:0] first, int cols, int sw,
                                         int sh);
    tile_txn_t t;
    t = tile_txn($urandom, POS_W'($urandom), POS_W'($urandom));
    t.operation        = OP_LOAD;
    t.entry_slot       = slot[SLOT_W-1:0];
    t.entry_first_gid  = first;
    t.entry_columns    = cols[COLS_W-1:0];
    t.entry_src_width  = sw[PIX_W-1:0];
    t.entry_src_height = sh[PIX_W-1:0];
    return t;
  endfunction

  function automatic tile_txn_t random_txn();
    tile_txn_t t;
    int r;
    int k;
    logic [ID_W-1:0] id;
    t = tile_txn($urandom, POS_W'($urandom), POS_W'($urandom));
    r = $urandom_range(0, 99);
    if (r < 12) begin
      t.operation = OP_LOAD;
      r = $urandom_range(0, 9);
      if (r < 6) t.entry_first_gid = ID_W'($urandom_range(0, 3000));
      else if (r == 9) t.entry_first_gid = ID_W'(~32'd0 - $urandom_range(0, 50));
      r = $urandom_range(0, 9);
      if (r == 0) t.entry_columns = '0;
      else if (r < 7) t.entry_columns = COLS_W'($urandom_range(1, 16));
      return t;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      t.raw_gid = '0;
    end else if (r < 70) begin
      k = $urandom_range(0, MAX_TILESETS - 1);
      id = ID_W'(pred.tileset[k].first_gid + $urandom_range(0, 40));
      t.raw_gid = {3'($urandom), id};
    end else if (r < 85) begin
      id = ID_W'($urandom_range(0, 64));
      t.raw_gid = {3'($urandom), id};
    end
    return t;
  endfunction

  task automatic push_txn(tile_txn_t t);
    in_tile.valid            <= 1'b1;
    in_tile.operation        <= t.operation;
    in_tile.raw_gid          <= t.raw_gid;
    in_tile.tile_col         <= t.tile_col;
    in_tile.tile_row         <= t.tile_row;
    in_tile.entry_slot       <= t.entry_slot;
    in_tile.entry_first_gid  <= t.entry_first_gid;
    in_tile.entry_columns    <= t.entry_columns;
    in_tile.entry_src_width  <= t.entry_src_width;
    in_tile.entry_src_height <= t.entry_src_height;
    in_high = 1'b1;
    do @(posedge clk); while (in_tile.ready !== 1'b1);
    pred.note_transaction(t);
    burst_left--;
    if (burst_left <= 0) begin
      in_tile.valid <= 1'b0;
      in_high = 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(10, 50)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
    end
  endtask

  // wait until every quad is out, plus enough for a tile that draws nothing
  task automatic drain();
    if (in_high) begin
      in_tile.valid <= 1'b0;
      in_high = 1'b0;
      @(posedge clk);
    end
    while (pred.pending_corners.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic reconfigure(int w, int h, int n);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAP_TILE_WIDTH;
    cfg_wdata <= w[CFG_DW-1:0];
    @(posedge clk);
    cfg_index <= CFG_MAP_TILE_HEIGHT;
    cfg_wdata <= h[CFG_DW-1:0];
    @(posedge clk);
    cfg_index <= CFG_TILESETS_IN_USE;
    cfg_wdata <= n[CFG_DW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    pred.map_w  = w[PIX_W-1:0];
    pred.map_h  = h[PIX_W-1:0];
    pred.in_use = n[CNT_W-1:0];
  endtask

  // result side: stall pattern switches among four modes, picked at random
  initial begin
    int rdy_mode;
    int unsigned rdy_cnt;
    rdy_mode = 0;
    rdy_cnt  = 0;
    out_quad.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_quad.valid === 1'b1 && out_quad.ready === 1'b1)
        pred.check_corner('{out_quad.corner, out_quad.screen_x, out_quad.screen_y,
                            out_quad.tex_u, out_quad.tex_v, out_quad.tileset_slot,
                            out_quad.last_corner});
      rdy_cnt++;
      if (rdy_cnt % 96 == 0) rdy_mode = $urandom_range(0, 3);
      case (rdy_mode)
        0: out_quad.ready <= 1'b1;
        1: out_quad.ready <= 1'($urandom_range(0, 1));
        2: out_quad.ready <= (rdy_cnt % 3 == 0);
        default: out_quad.ready <= (rdy_cnt % 16 >= 12);
      endcase
    end
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_MAP_TILE_WIDTH;
    cfg_wdata <= '0;
    in_tile.valid            <= 1'b0;
    in_tile.operation        <= OP_LOAD;
    in_tile.raw_gid          <= '0;
    in_tile.tile_col         <= '0;
    in_tile.tile_row         <= '0;
    in_tile.entry_slot       <= '0;
    in_tile.entry_first_gid  <= '0;
    in_tile.entry_columns    <= '0;
    in_tile.entry_src_width  <= '0;
    in_tile.entry_src_height <= '0;
    in_high    = 1'b0;
    burst_left = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // nothing searched at reset count
    push_txn(tile_txn({3'b000, 29'd5}, 10'd0, 10'd0));
    push_txn(tile_txn({3'b111, 29'd1}, '1, '1));

    push_txn(load_txn(0, 29'd1, 4, 16, 16));
    push_txn(load_txn(1, 29'd100, 8, 32, 24));
    push_txn(load_txn(2, 29'd200, 1, 255, 255));
    push_txn(load_txn(3, 29'd300, 5, 10, 12));
    push_txn(load_txn(4, 29'd400, 1023, 1, 1));
    push_txn(load_txn(5, 29'd500, 0, 8, 8));
    push_txn(load_txn(6, 29'd600, 16, 0, 255));
    push_txn(load_txn(7, 29'h1FFF_FF00, 1023, 255, 255));

    reconfigure(255, 1, MAX_TILESETS);
    for (int f = 0; f < 8; f++)
      push_txn(tile_txn({f[2:0], 29'd307}, 10'(f * 3), 10'(1023 - f)));
    push_txn(tile_txn('0, 10'd5, 10'd5));
    push_txn(tile_txn(32'hE000_0000, 10'd7, 10'd9));
    push_txn(tile_txn(32'h1FFF_FFFF, '1, '1));
    push_txn(tile_txn(32'h4000_01F9, 10'd1, 10'd2));
    push_txn(tile_txn(32'd250, '0, '0));

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: reconfigure(1, 255, 15);
        1: reconfigure(255, 255, 1);
        2: reconfigure(0, 1, 9);
        default: reconfigure($urandom_range(1, 255), $urandom_range(1, 255),
                             $urandom_range(0, 15));
      endcase
      for (int i = 0; i < 36; i++) push_txn(random_txn());
    end

    drain();
    if (pred.fail_count == 0) begin
      $display("[tile_gid_quad_generator_top] OK");
    end else begin
      $display("[tile_gid_quad_generator_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tqg_pkg.sv
sv/tqg_if.sv
sv/tile_gid_quad_generator_top.sv
tb/tb_tile_gid_quad_generator_top.sv
